[hdl/bcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg
// shared types and constants for the button click classifier
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int StampWidth = 32;
    localparam int LimitWidth = 16;

    localparam logic [LimitWidth-1:0] LONG_PRESS_RESET = 16'd1500;
    localparam logic [LimitWidth-1:0] CLICK_GAP_RESET  = 16'd400;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_LONG_PRESS = 1'b0,
        CFG_CLICK_GAP  = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_PRESSED = 3'd1,
        MODE_PENDING = 3'd2,
        MODE_SECOND  = 3'd3,
        MODE_LONG    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_t;

    typedef struct packed {
        logic                  level;
        logic [StampWidth-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic [LimitWidth-1:0] long_press;
        logic [LimitWidth-1:0] click_gap;
    } limits_t;

endpackage

[hdl/bcc_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_fsm
// press/release state machine with press and release timestamps
// ----------------------------------------------------------------------------
module bcc_fsm
    import bcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  sample_t sample,
    input  limits_t limits,
    output event_t  click_event
);

    mode_t                 mode_reg;
    mode_t                 mode_next;
    logic [StampWidth-1:0] press_stamp_reg;
    logic [StampWidth-1:0] press_stamp_next;
    logic [StampWidth-1:0] release_stamp_reg;
    logic [StampWidth-1:0] release_stamp_next;

    logic [StampWidth-1:0] held_time;
    logic [StampWidth-1:0] gap_time;
    logic                  long_hit;
    logic                  gap_hit;

    // wrapping elapsed times
    assign held_time = sample.now_ms - press_stamp_reg;
    assign gap_time  = sample.now_ms - release_stamp_reg;
    assign long_hit  = held_time > {{(StampWidth-LimitWidth){1'b0}}, limits.long_press};
    assign gap_hit   = gap_time > {{(StampWidth-LimitWidth){1'b0}}, limits.click_gap};

    always_comb
    begin
        mode_next          = mode_reg;
        press_stamp_next   = press_stamp_reg;
        release_stamp_next = release_stamp_reg;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (sample.level)
                begin
                    press_stamp_next = sample.now_ms;
                    mode_next        = MODE_PRESSED;
                end
            end
            MODE_PRESSED:
            begin
                if (sample.level)
                begin
                    if (long_hit)
                        mode_next = MODE_LONG;
                end
                else
                begin
                    release_stamp_next = sample.now_ms;
                    mode_next          = MODE_PENDING;
                end
            end
            MODE_PENDING:
            begin
                if (sample.level)
                begin
                    press_stamp_next = sample.now_ms;
                    mode_next        = MODE_SECOND;
                end
                else if (gap_hit)
                    mode_next = MODE_IDLE;
            end
            MODE_SECOND:
            begin
                if (sample.level)
                begin
                    if (long_hit)
                        mode_next = MODE_LONG;
                end
                else
                    mode_next = MODE_IDLE;
            end
            MODE_LONG:
            begin
                if (!sample.level)
                    mode_next = MODE_IDLE;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_comb
    begin
        click_event = EV_NONE;
        case (mode_reg)
            MODE_PRESSED:
            begin
                if (sample.level && long_hit)
                    click_event = EV_LONG;
            end
            MODE_PENDING:
            begin
                if (!sample.level && gap_hit)
                    click_event = EV_SINGLE;
            end
            MODE_SECOND:
            begin
                if (sample.level && long_hit)
                    click_event = EV_LONG;
                else if (!sample.level)
                    click_event = EV_DOUBLE;
            end
            default:
            begin
                click_event = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            press_stamp_reg   <= '0;
            release_stamp_reg <= '0;
        end
        else if (step)
        begin
            mode_reg          <= mode_next;
            press_stamp_reg   <= press_stamp_next;
            release_stamp_reg <= release_stamp_next;
        end
    end

endmodule

[hdl/button_click_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_classifier
// classifies button samples into single, double and long press events
// ----------------------------------------------------------------------------
// Every accepted sample word (button level plus millisecond timestamp) gives
// exactly one result word on the output channel: none, single click, double
// click or long press. A sample sits in the input register, where the state
// machine and the two 32-bit elapsed time compares evaluate it, and its event
// lands in the output register; the throughput is one word per cycle as long
// as the output side keeps taking words. The two limit registers are written
// on the configuration channel (index 0 long press, index 1 click gap); the
// user must write them only while the block is idle, which the block itself
// does not enforce.
module button_click_classifier
    import bcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  button_level,
    input  logic [StampWidth-1:0] now_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            click_event,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [LimitWidth-1:0] cfg_data
);

    limits_t limits_reg;
    logic    s1_valid_reg;
    sample_t s1_sample_reg;
    logic    out_valid_reg;
    event_t  event_reg;
    event_t  event_next;
    logic    advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.long_press <= LONG_PRESS_RESET;
            limits_reg.click_gap  <= CLICK_GAP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LONG_PRESS: limits_reg.long_press <= cfg_data;
                CFG_CLICK_GAP:  limits_reg.click_gap  <= cfg_data;
                default:        limits_reg            <= limits_reg;
            endcase
        end
    end

    // a word moves to the output register when that register is free or drains
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_sample_reg.level  <= button_level;
            s1_sample_reg.now_ms <= now_ms;
        end
    end

    bcc_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .sample      (s1_sample_reg),
        .limits      (limits_reg),
        .click_event (event_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            event_reg <= event_next;
    end

    assign out_valid   = out_valid_reg;
    assign click_event = event_reg;

endmodule

[sim/tb_button_click_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_click_classifier
// self-checking bench for the button click classifier
// ----------------------------------------------------------------------------
// Feeds button sample words (level plus millisecond stamp) through the input
// handshake and checks every event word against an in-bench copy of the
// click state machine. A short directed run hits the limit edges, the held
// long press and the stamp wrap. Random press gestures follow, with
// single, double and long presses timed around the limits, mixed with noise.
// The limit registers are rewritten between phases, including zero and full
// scale. Both handshakes idle at random, and one long output stall fills
// the block.
// ----------------------------------------------------------------------------
module tb_button_click_classifier;
    import bcc_pkg::*;

    localparam int unsigned LONG_HOLD     = 90;
    localparam int unsigned WATCHDOG_MAX  = 4000;
    localparam int unsigned PRINT_MAX     = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  button_level;
    logic [StampWidth-1:0] now_ms;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            click_event;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [0:0]            cfg_index;
    logic [LimitWidth-1:0] cfg_data;

    button_click_classifier DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .button_level (button_level),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .click_event  (click_event),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // classifier copy
    mode_t                 press_mode = MODE_IDLE;
    logic [StampWidth-1:0] press_at   = '0;
    logic [StampWidth-1:0] release_at = '0;
    logic [LimitWidth-1:0] long_limit = LONG_PRESS_RESET;
    logic [LimitWidth-1:0] gap_limit  = CLICK_GAP_RESET;

    sample_t               pending_samples[$];
    event_t                expected_events[$];
    int unsigned           queued_total   = 0;
    int unsigned           accepted_total = 0;
    int unsigned           error_count    = 0;
    int unsigned           idle_cycles    = 0;
    bit                    sample_taken   = 1'b0;
    int unsigned           feed_wait      = 0;
    int unsigned           sink_wait      = 0;
    bit                    feed_calm      = 1'b0;
    bit                    sink_calm      = 1'b0;
    int unsigned           hold_requests  = 0;
    int unsigned           hold_served    = 0;
    logic [StampWidth-1:0] stamp_now;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic event_t classify_sample(logic level, logic [StampWidth-1:0] t);
        logic [StampWidth-1:0] held;
        logic [StampWidth-1:0] released;
        event_t                ev;
        held     = t - press_at;
        released = t - release_at;
        ev       = EV_NONE;
        // first matching rule wins
        if (level && press_mode == MODE_IDLE)
        begin
            press_at   = t;
            press_mode = MODE_PRESSED;
        end
        else if ((press_mode == MODE_PRESSED || press_mode == MODE_SECOND) && level &&
                 held > StampWidth'(long_limit))
        begin
            press_mode = MODE_LONG;
            ev         = EV_LONG;
        end
        else if (press_mode == MODE_PRESSED && !level)
        begin
            release_at = t;
            press_mode = MODE_PENDING;
        end
        else if (press_mode == MODE_PENDING && !level && released > StampWidth'(gap_limit))
        begin
            press_mode = MODE_IDLE;
            ev         = EV_SINGLE;
        end
        else if (press_mode == MODE_PENDING && level)
        begin
            press_at   = t;
            press_mode = MODE_SECOND;
        end
        else if (press_mode == MODE_SECOND && !level)
        begin
            press_mode = MODE_IDLE;
            ev         = EV_DOUBLE;
        end
        else if (press_mode == MODE_LONG && !level)
        begin
            press_mode = MODE_IDLE;
        end
        return ev;
    endfunction

    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // elapsed time close to a limit, with a few far-off picks
    function automatic logic [StampWidth-1:0] span_near(logic [LimitWidth-1:0] limit);
        case ($urandom_range(0, 5))
            0: return (limit == 0) ? '0 : StampWidth'(limit) - 1;
            1: return StampWidth'(limit);
            2: return StampWidth'(limit) + 1;
            3: return StampWidth'(limit) + $urandom_range(2, 300);
            4: return $urandom_range(0, limit);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= PRINT_MAX)
            $display("mismatch at %0t ns: %s", $realtime, what);
    endtask

    task automatic queue_sample(logic level, logic [StampWidth-1:0] t);
        sample_t word;
        word.level  = level;
        word.now_ms = t;
        pending_samples.push_back(word);
        queued_total++;
    endtask

    task automatic queue_gesture();
        logic [StampWidth-1:0] t;
        logic [StampWidth-1:0] rel;
        logic [StampWidth-1:0] sec;
        t = stamp_now;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                // single click, sometimes held past the limit
                queue_sample(1'b1, t);
                if ($urandom_range(0, 3) == 0)
                    queue_sample(1'b1, t + span_near(long_limit));
                rel = t + $urandom_range(0, long_limit);
                queue_sample(1'b0, rel);
                queue_sample(1'b0, rel + span_near(gap_limit));
                stamp_now = rel + StampWidth'(gap_limit) + 1;
                queue_sample(1'b0, stamp_now);
            end
            3, 4, 5:
            begin
                // double click, second press may turn into a long press
                queue_sample(1'b1, t);
                rel = t + $urandom_range(0, long_limit);
                queue_sample(1'b0, rel);
                sec = rel + $urandom_range(0, gap_limit);
                queue_sample(1'b1, sec);
                if ($urandom_range(0, 2) == 0)
                    queue_sample(1'b1, sec + span_near(long_limit));
                stamp_now = sec + $urandom_range(0, long_limit);
                queue_sample(1'b0, stamp_now);
            end
            6, 7:
            begin
                queue_sample(1'b1, t);
                queue_sample(1'b1, t + span_near(long_limit));
                queue_sample(1'b1, t + StampWidth'(long_limit) + 1);
                stamp_now = t + StampWidth'(long_limit) + $urandom_range(2, 3000);
                queue_sample(1'b1, stamp_now);
                queue_sample(1'b0, stamp_now + 1);
            end
            default:
            begin
                repeat ($urandom_range(1, 4))
                    queue_sample(1'($urandom_range(0, 1)),
                                 $urandom_range(0, 1) ? $urandom
                                                      : stamp_now + $urandom_range(0, 2000));
            end
        endcase
        stamp_now = stamp_now + $urandom_range(1, 200);
    endtask

    task automatic run_gestures(int unsigned count);
        int unsigned target;
        target = queued_total + count;
        while (queued_total < target)
            queue_gesture();
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_total != queued_total || expected_events.size() != 0);
    endtask

    task automatic write_limit(cfg_index_t idx, logic [LimitWidth-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_LONG_PRESS)
            long_limit = value;
        else
            gap_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(logic [LimitWidth-1:0] long_ms, logic [LimitWidth-1:0] gap_ms);
        wait_drained();
        repeat (4) @(negedge clk);
        write_limit(CFG_LONG_PRESS, long_ms);
        write_limit(CFG_CLICK_GAP, gap_ms);
    endtask

    // driver: one sample word per handshake
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || sample_taken)
            begin
                if (feed_wait != 0)
                begin
                    feed_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    sample_t word;
                    word = pending_samples.pop_front();
                    in_valid     <= 1'b1;
                    button_level <= word.level;
                    now_ms       <= word.now_ms;
                    feed_wait    = pick_gap(feed_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side ready, with random stalls and the requested long hold
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                sink_wait   = LONG_HOLD;
            end
            if (sink_wait != 0)
            begin
                sink_wait--;
                out_ready <= 1'b0;
            end
            else if (!sink_calm && $urandom_range(0, 3) == 0)
            begin
                sink_wait = pick_gap(1'b0);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            event_t want;
            sample_taken = in_valid && in_ready;
            if (sample_taken)
            begin
                expected_events.push_back(classify_sample(button_level, now_ms));
                accepted_total++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    report_mismatch($sformatf("event %0d with none expected", click_event));
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (click_event !== want)
                        report_mismatch($sformatf("click_event %0d, expected %0d",
                                                  click_event, want));
                end
            end
            if (sample_taken || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        button_level = 1'b0;
        now_ms       = '0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_LONG_PRESS;
        cfg_data     = '0;
        stamp_now    = $urandom;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed run at reset limits
        queue_sample(1'b0, 32'd0);
        queue_sample(1'b1, 32'd100);
        queue_sample(1'b1, 32'd1600);         // held exactly the limit
        queue_sample(1'b1, 32'd1601);         // one past: long press
        queue_sample(1'b1, 32'd5000);         // still held, no repeat
        queue_sample(1'b0, 32'd5001);
        queue_sample(1'b1, 32'd6000);
        queue_sample(1'b0, 32'd6100);
        queue_sample(1'b0, 32'd6500);         // gap exactly the limit
        queue_sample(1'b0, 32'd6501);         // single click
        queue_sample(1'b1, 32'd7000);
        queue_sample(1'b0, 32'd7050);
        queue_sample(1'b1, 32'd7200);
        queue_sample(1'b0, 32'd7300);         // double click
        queue_sample(1'b1, 32'd8000);
        queue_sample(1'b0, 32'd8010);
        queue_sample(1'b1, 32'd8020);
        queue_sample(1'b1, 32'd9521);         // second press held long
        queue_sample(1'b0, 32'd9600);
        // stamps wrapping through zero
        queue_sample(1'b1, 32'hFFFF_FF00);
        queue_sample(1'b0, 32'h0000_0010);
        queue_sample(1'b0, 32'hFFFF_FFFF);
        queue_sample(1'b1, 32'hFFFF_FFFF);
        queue_sample(1'b1, 32'h0000_05DC);
        queue_sample(1'b0, 32'h0000_0000);
        wait_drained();

        set_limits('0, '0);
        run_gestures(220);

        // long output stall while words keep coming
        set_limits(16'hFFFF, 16'hFFFF);
        feed_calm = 1'b1;
        hold_requests++;
        run_gestures(220);
        wait_drained();
        feed_calm = 1'b0;

        set_limits(LimitWidth'($urandom_range(0, 16'hFFFF)),
                   LimitWidth'($urandom_range(0, 16'hFFFF)));
        sink_calm = 1'b1;
        run_gestures(130);
        wait_drained();
        sink_calm = 1'b0;
        run_gestures(130);

        set_limits(16'd3, 16'd1);
        run_gestures(220);

        set_limits(LONG_PRESS_RESET, CLICK_GAP_RESET);
        run_gestures(350);

        wait_drained();
        repeat (20) @(posedge clk);
        if (expected_events.size() != 0)
            report_mismatch($sformatf("%0d events never arrived", expected_events.size()));
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
hdl/bcc_pkg.sv
hdl/bcc_fsm.sv
hdl/button_click_classifier.sv
sim/tb_button_click_classifier.sv
